/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;
  localparam int FILL_W   = 4;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } spq_req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // One stored slot
  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } spq_entry_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } spq_ctl_t;

endpackage

/* hdl/spq_if.sv */
// Valid/ready channel interfaces for requests and results.
interface spq_in_if;
  import spq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [VALUE_W-1:0] value_in;
  logic signed [PRIO_W-1:0]  prio_in;

  modport source (output valid, req_type, value_in, prio_in, input ready);
  modport sink   (input valid, req_type, value_in, prio_in, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] value_out;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, status, value_out, fill_count, input ready);
  modport sink   (input valid, status, value_out, fill_count, output ready);
endinterface

/* hdl/spq_cell.sv */
// One slot of the sorted chain: holds an entry, shifts toward head or tail.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::spq_ctl_t   ctl,
  input  logic                occ,        // slot currently holds a live entry
  input  logic                left_keep,  // predecessor keeps its entry on insert
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t entry,
  output logic                keep
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // An occupied entry stays on insert if its priority is equal or higher than the new one
  assign keep = occ && ($signed(entry_r.prio) >= $signed(ctl.prio));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rem) begin
      entry_nxt = right_entry;
    end else if (ctl.ins && !keep) begin
      if (left_keep) begin
        entry_nxt.prio  = ctl.prio;
        entry_nxt.value = ctl.value;
      end else begin
        entry_nxt = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* hdl/sorted_priority_queue_core.sv */
// Top level: sorted priority queue built as a chain of shifting cells.
//
// Requests arrive on in_chan (req_type, value_in, prio_in), one result per
// request leaves on out_chan (status, value_out, fill_count). Both are
// valid/ready; a transaction completes when valid and ready are high at a
// rising clock edge.
// Every cell compares its priority with the incoming one in parallel and
// either holds, takes the new entry, or takes its neighbor's entry, so the
// whole queue updates in the cycle a request is accepted.
// The result is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; every cell updates at acceptance.
// The result sits in an output register; a new request is accepted in the
// same cycle the held result is taken, so a stalled receiver stops intake
// only while its result is still waiting.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; stored slot contents are not cleared and are never read while
// unoccupied.
module sorted_priority_queue_core (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  spq_status_t      status_r, status_nxt;
  logic [VALUE_W-1:0] vout_r, vout_nxt;

  logic       accept;
  logic       full, empty;
  spq_ctl_t   ctl;
  spq_entry_t entries [CAPACITY];
  logic [CAPACITY-1:0] keeps;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (count_r == CNT_W'(CAPACITY));
  assign empty         = (count_r == '0);

  // Command broadcast to the chain
  always_comb begin
    ctl.ins   = accept && (in_chan.req_type == REQ_INSERT) && !full;
    ctl.rem   = accept && (in_chan.req_type == REQ_REMOVE) && !empty;
    ctl.prio  = in_chan.prio_in;
    ctl.value = in_chan.value_in;
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       occ;
    logic       lk;
    spq_entry_t le, re;
    assign occ = (count_r > CNT_W'(i));
    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign le = entries[0];
    end else begin : g_mid
      assign lk = keeps[i-1];
      assign le = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign re = entries[i];
    end else begin : g_body
      assign re = entries[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ),
      .left_keep   (lk),
      .left_entry  (le),
      .right_entry (re),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

  // Count and result
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    vout_nxt   = '0;
    if (in_chan.req_type == REQ_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        vout_nxt  = entries[0].value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      vout_r   <= vout_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = status_r;
  assign out_chan.value_out  = vout_r;
  assign out_chan.fill_count = FILL_W'(count_r);

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Remove on empty reports empty and leaves the count at zero
  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_chan.req_type == REQ_REMOVE) && empty
    |=> out_valid_r && (status_r == ST_EMPTY) && (count_r == '0))
    else $error("remove on empty queue misreported");

  // Successful insert grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_chan.req_type == REQ_INSERT) && !full
    |=> (count_r == $past(count_r) + CNT_W'(1)) && (status_r == ST_DONE))
    else $error("insert did not grow queue");

  // Insert into a full queue changes nothing
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_chan.req_type == REQ_INSERT) && full
    |=> $stable(count_r) && (status_r == ST_FULL))
    else $error("insert into full queue not rejected");

endmodule

/* dv/sorted_priority_queue_checker.sv */
// Checker for the sorted priority queue: tracks the queue contents and compares every result.
module sorted_priority_queue_checker (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    req_mon,
  spq_out_if   rsp_mon,
  output int   error_count,
  output int   outstanding
);
  import spq_pkg::*;

  typedef struct {
    spq_status_t               status;
    logic signed [VALUE_W-1:0] value;
    logic [FILL_W-1:0]         fill;
  } reply_t;

  // Shadow copy of the queue, head in slot 0
  logic signed [VALUE_W-1:0] model_value [CAPACITY];
  logic signed [PRIO_W-1:0]  model_prio  [CAPACITY];
  int                        model_fill;

  reply_t owed_replies [$];
  int     errs;

  initial begin
    model_fill  = 0;
    errs        = 0;
    error_count = 0;
    outstanding = 0;
  end

  // Apply one request to the shadow queue and return the reply it must produce
  function automatic reply_t apply_request(logic req, logic signed [VALUE_W-1:0] val,
                                           logic signed [PRIO_W-1:0] prio);
    reply_t r;
    int     pos;
    int     k;
    r.status = ST_DONE;
    r.value  = '0;
    if (req == REQ_INSERT) begin
      if (model_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < model_fill && prio <= model_prio[pos]) pos++;
        for (k = model_fill; k > pos; k--) begin
          model_value[k] = model_value[k-1];
          model_prio[k]  = model_prio[k-1];
        end
        model_value[pos] = val;
        model_prio[pos]  = prio;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = model_value[0];
        for (k = 0; k + 1 < model_fill; k++) begin
          model_value[k] = model_value[k+1];
          model_prio[k]  = model_prio[k+1];
        end
        model_fill--;
      end
    end
    r.fill = model_fill[FILL_W-1:0];
    return r;
  endfunction

  // Results first: a result never belongs to a request taken at the same edge
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      model_fill = 0;
      owed_replies.delete();
    end else begin
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (owed_replies.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result with nothing owed: status %0d value %0h fill %0d", $time,
                     rsp_mon.status, rsp_mon.value_out, rsp_mon.fill_count);
        end else begin
          want = owed_replies.pop_front();
          if (rsp_mon.status !== want.status || rsp_mon.value_out !== want.value ||
              rsp_mon.fill_count !== want.fill) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: status %0d/%0d value %0h/%0h fill %0d/%0d (exp/got)",
                       $time, want.status, rsp_mon.status, want.value, rsp_mon.value_out,
                       want.fill, rsp_mon.fill_count);
          end
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
        owed_replies.push_back(apply_request(req_mon.req_type, req_mon.value_in,
                                             req_mon.prio_in));
    end
    error_count <= errs;
    outstanding <= owed_replies.size();
  end

endmodule

/* dv/sorted_priority_queue_core_tb.sv */
// Testbench top for the sorted priority queue: stimulus, flow control, watchdog and verdict.
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_ITEMS   = 500;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 150;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   error_count;
  int   outstanding;
  int   quiet_cycles;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sorted_priority_queue_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_chan),
    .rsp_mon     (out_chan),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // Clock, period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: cycles with no transaction on either channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_priority_queue_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request after a random gap and hold it until taken
  task automatic send_request(input spq_req_t req, input logic signed [VALUE_W-1:0] val,
                              input logic signed [PRIO_W-1:0] prio);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.req_type <= req;
    in_chan.value_in <= val;
    in_chan.prio_in  <= prio;
    in_chan.valid    <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int sel;
    int t;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      // narrow band so ties are common
      t = $urandom_range(0, 4);
      return PRIO_W'(t - 2);
    end else if (sel < 8) begin
      return PRIO_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return VALUE_W'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      default: return 32'shFFFF_FFFF;
    endcase
  endfunction

  // Result side: random hold-off per result, one long hold to back up the queue
  initial begin : result_sink
    int wait_n;
    int taken;
    out_chan.ready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken == HOLD_AT) wait_n = HOLD_CYCLES;
      else wait_n = no_idle ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        out_chan.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      taken++;
      @(negedge clk);
    end
  end

  // Request side: directed cases, then random traffic
  initial begin : request_source
    int i;
    int mode;
    int phase_left;
    int ins_pct;
    in_chan.valid    = 1'b0;
    in_chan.req_type = REQ_INSERT;
    in_chan.value_in = '0;
    in_chan.prio_in  = '0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // remove on empty, with junk fields that must be ignored
    send_request(REQ_REMOVE, 32'sh1234_5678, 16'sh7FFF);
    // priority extremes and ties on both ends
    send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'sh8000);
    send_request(REQ_INSERT, 32'sh8000_0000, 16'sh7FFF);
    send_request(REQ_INSERT, 32'sh0000_0000, 16'sh0000);
    send_request(REQ_INSERT, 32'shFFFF_FFFF, 16'sh0000);
    send_request(REQ_INSERT, 32'sh5555_5555, 16'shFFFF);
    send_request(REQ_INSERT, 32'shAAAA_AAAA, 16'sh7FFF);
    send_request(REQ_INSERT, 32'sh0F0F_0F0F, 16'sh0064);
    send_request(REQ_INSERT, 32'shF0F0_F0F0, 16'sh8000);
    // full: rejected
    send_request(REQ_INSERT, 32'shDEAD_BEEF, 16'sh7FFF);
    // drain in priority order, then remove on empty again
    send_request(REQ_REMOVE, 32'shFFFF_FFFF, 16'shFFFF);
    repeat (7) send_request(REQ_REMOVE, VALUE_W'($urandom), PRIO_W'($urandom));
    send_request(REQ_REMOVE, 32'sh0000_0000, 16'sh8000);
    // single entry in and out
    send_request(REQ_INSERT, 32'sh0000_0001, 16'sh0005);
    send_request(REQ_REMOVE, 32'sh0000_0000, 16'sh0000);

    // Random traffic in phases that fill, drain or hover
    phase_left = 0;
    ins_pct = 50;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(15, 50);
        case (mode)
          0: ins_pct = 80;
          1: ins_pct = 25;
          default: ins_pct = 50;
        endcase
      end
      phase_left--;
      no_idle = (i >= 120 && i < 180) || (i >= 380 && i < 430);
      if ($urandom_range(0, 99) < ins_pct)
        send_request(REQ_INSERT, pick_value(), pick_prio());
      else
        send_request(REQ_REMOVE, VALUE_W'($urandom), PRIO_W'($urandom));
    end
    in_chan.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then keep watching for stray results before the verdict
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("sorted_priority_queue_core_tb: clean");
    end else begin
      $display("sorted_priority_queue_core_tb: errors");
    end
    $finish;
  end

endmodule
